[hdl/erc_pkg.sv]
// Shared types and constants for the elevator request cost bidder.
// Holds command/button codes, field widths and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

    // default number of floors in the request table
    localparam int FLOORS_DEF = 4;

    // field widths
    localparam int CMD_W      = 3;
    localparam int FLOOR_W    = 2;
    localparam int BTN_W      = 2;
    localparam int EXT_W      = 16;
    localparam int COST_W     = 11;
    localparam int ROW_W      = 4;
    localparam int TMO_W      = 8;
    localparam int NODE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PRESS       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOTE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOTE_DONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK        = 3'd4;

    // button codes
    localparam logic [BTN_W-1:0] BTN_UP   = 2'd0;
    localparam logic [BTN_W-1:0] BTN_DOWN = 2'd1;
    localparam logic [BTN_W-1:0] BTN_CAB  = 2'd2;
    localparam logic [BTN_W-1:0] BTN_BAD  = 2'd3;

    // bit positions in a table row
    localparam int F_UP   = 0;
    localparam int F_DOWN = 1;
    localparam int F_CAB  = 2;
    localparam int F_RESP = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    localparam logic [TMO_W-1:0]  TMO_RST    = 8'd25;
    localparam logic [COST_W-1:0] COST_SAT   = 11'd2047;
    localparam int                COST_SHIFT = 8;   // cost step of 255 = (n << 8) - n
    localparam int                MAX_RES    = 4;   // re-bids served per tick

    // decoded operation of the latched transaction
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ROW    = 3'd1,
        OP_HANDLE = 3'd2,
        OP_FINISH = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_TICK   = 3'd5
    } op_t;

    // table update plus result load
    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_ZERO   = 3'd1,
        ACT_ROW    = 3'd2,
        ACT_FINISH = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_DECIDE = 3'd5
    } act_t;

    typedef struct packed {
        logic load_in;
        logic set_flag;
        logic count;
        logic cost;
        logic tick_dec;
        logic tick_mask;
        logic scan_pick;
        logic scan_disarm;
        logic scan_next;
        act_t act;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_free;
        logic tick_mode;
        logic scan_expired;
        logic scan_hall;
        logic scan_end;
        logic rebid_full;
        logic none_sent;
    } ctl_status_t;

endpackage

`default_nettype wire

[hdl/erc_datapath.sv]
// Datapath of the request cost bidder: request table, timeouts, cost pipeline, result register.
// Depends on erc_pkg; driven by erc_ctrl through ctl_cmd_t / ctl_status_t.
`timescale 1ns / 1ps
`default_nettype none

module erc_datapath #(
    parameter int FLOORS = erc_pkg::FLOORS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [erc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [erc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic [erc_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [erc_pkg::FLOOR_W-1:0]      s_floor,
    input  wire logic [erc_pkg::BTN_W-1:0]        s_button,
    input  wire logic [erc_pkg::EXT_W-1:0]        s_ext_cost,
    input  wire logic [erc_pkg::FLOOR_W-1:0]      s_current_floor,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_send_valid,
    output logic                                  m_send_kind,
    output logic [erc_pkg::FLOOR_W-1:0]           m_send_floor,
    output logic [erc_pkg::BTN_W-1:0]             m_send_button,
    output logic [erc_pkg::COST_W-1:0]            m_send_cost,
    output logic [erc_pkg::ROW_W-1:0]             m_floor_flags,
    output logic                                  m_last,
    input  wire erc_pkg::ctl_cmd_t                cmd,
    output erc_pkg::ctl_status_t                  status
);
    import erc_pkg::*;

    localparam int AW   = $clog2(FLOORS);
    localparam int FW   = (AW > FLOOR_W) ? AW : FLOOR_W;
    localparam int CW   = $clog2(FLOORS + 1);
    localparam int NW   = $clog2(2 * FLOORS + 4);
    localparam int CSTW = NW + COST_SHIFT;
    localparam int CMPW = (CSTW > EXT_W) ? CSTW : EXT_W;
    localparam int RW   = $clog2(MAX_RES + 1);

    localparam logic [FW:0]   FLOORS_F = (FW + 1)'(FLOORS);
    localparam logic [AW:0]   FLOORS_A = (AW + 1)'(FLOORS);
    localparam logic [AW-1:0] TOP_ADDR = AW'(FLOORS - 1);
    localparam logic [ROW_W-1:0] CAB_MASK = ROW_W'(1) << F_CAB;

    // state
    logic [ROW_W-1:0]  req_reg   [FLOORS];
    logic [ROW_W-1:0]  req_next  [FLOORS];
    logic [TMO_W-1:0]  tleft_reg [FLOORS];
    logic [TMO_W-1:0]  tleft_next[FLOORS];
    logic [FLOORS-1:0] armed_reg, armed_next;
    logic [FLOORS-1:0] pend_reg, pend_next;
    logic [NODE_W-1:0] node_id_reg, node_id_next;
    logic [TMO_W-1:0]  tmo_ticks_reg, tmo_ticks_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [RW-1:0]     nres_reg, nres_next;

    // latched transaction and pipeline payload
    logic [CMD_W-1:0]   in_cmd_reg;
    logic [FLOOR_W-1:0] in_floor_reg;
    logic [BTN_W-1:0]   btn_reg, btn_next;
    logic [EXT_W-1:0]   ext_reg;
    logic [FLOOR_W-1:0] cur_reg;
    logic [NW-1:0]      n_reg, n_next;
    logic [CSTW-1:0]    cost_reg, cost_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic                send_valid_reg, send_valid_next;
    logic                send_kind_reg, send_kind_next;
    logic [FLOOR_W-1:0]  send_floor_reg, send_floor_next;
    logic [BTN_W-1:0]    send_button_reg, send_button_next;
    logic [COST_W-1:0]   send_cost_reg, send_cost_next;
    logic [ROW_W-1:0]    flags_reg, flags_next;
    logic                last_reg, last_next;

    // combinational helpers
    logic               addr_ok, floor_ok, tick_mode;
    logic [ROW_W-1:0]   row;
    op_t                op;
    logic [CW-1:0]      load_cnt;
    logic [FW-1:0]      fa, fc, span;
    logic               hall, win, lose;
    logic [ROW_W-1:0]   row_dec;
    logic [COST_W-1:0]  cost_sat;
    logic [FLOORS-1:0]  pend_clr;
    logic               last_dec;

    assign addr_ok   = {1'b0, addr_reg} < FLOORS_A;
    assign floor_ok  = (FW + 1)'(in_floor_reg) < FLOORS_F;
    assign row       = addr_ok ? req_reg[addr_reg] : '0;
    assign tick_mode = (in_cmd_reg == CMD_TICK);

    always_comb begin
        if (in_cmd_reg == CMD_TICK) begin
            op = OP_TICK;
        end else if (in_cmd_reg > CMD_TICK || !floor_ok ||
                     ((in_cmd_reg == CMD_PRESS || in_cmd_reg == CMD_REMOTE) &&
                      btn_reg == BTN_BAD)) begin
            op = OP_NONE;
        end else begin
            case (in_cmd_reg)
                CMD_PRESS:   op = row[btn_reg] ? OP_ROW : OP_HANDLE;
                CMD_REMOTE:  op = OP_HANDLE;
                CMD_FINISH:  op = OP_FINISH;
                default:     op = OP_CLEAR;
            endcase
        end
    end

    // floors carrying load: a cab call, or an owned hall call
    always_comb begin
        load_cnt = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (req_reg[i][F_CAB] ||
                (req_reg[i][F_RESP] && (req_reg[i][F_UP] || req_reg[i][F_DOWN]))) begin
                load_cnt = load_cnt + CW'(1);
            end
        end
    end

    assign fa     = FW'(addr_reg);
    assign fc     = FW'(cur_reg);
    assign span   = (fa > fc) ? (fa - fc) : (fc - fa);
    assign n_next = NW'(span) + NW'(load_cnt);
    assign cost_next = (CSTW'(n_reg) << COST_SHIFT) - CSTW'(n_reg) + CSTW'(node_id_reg);

    // bid decision
    assign hall = (btn_reg != BTN_CAB);
    assign win  = (in_cmd_reg != CMD_REMOTE) || (CMPW'(cost_reg) < CMPW'(ext_reg));
    assign lose = (in_cmd_reg == CMD_REMOTE) && (CMPW'(cost_reg) > CMPW'(ext_reg));
    assign cost_sat = (cost_reg > CSTW'(COST_SAT)) ? COST_SAT : cost_reg[COST_W-1:0];

    always_comb begin
        row_dec = row;
        if (hall && win) begin
            row_dec[F_RESP] = 1'b1;
        end else if (hall && lose) begin
            row_dec[F_RESP] = 1'b0;
        end
    end

    assign pend_clr = pend_reg & ~(FLOORS'(1) << addr_reg);
    assign last_dec = !tick_mode || (nres_reg == RW'(MAX_RES - 1)) || (pend_clr == '0);

    // table, timeout and counter updates
    always_comb begin
        req_next       = req_reg;
        tleft_next     = tleft_reg;
        armed_next     = armed_reg;
        pend_next      = pend_reg;
        addr_next      = addr_reg;
        nres_next      = nres_reg;
        btn_next       = btn_reg;
        node_id_next   = node_id_reg;
        tmo_ticks_next = tmo_ticks_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_ID: node_id_next   = cfg_wdata;
                CFG_TIMEOUT: tmo_ticks_next = cfg_wdata;
                default:     node_id_next   = node_id_reg;
            endcase
        end

        if (cmd.load_in) begin
            addr_next = AW'(s_floor);
            btn_next  = s_button;
        end

        if (cmd.set_flag && addr_ok) begin
            req_next[addr_reg][btn_reg] = 1'b1;
        end

        if (cmd.tick_dec) begin
            for (int i = 0; i < FLOORS; i++) begin
                if (armed_reg[i] && tleft_reg[i] != '0) begin
                    tleft_next[i] = tleft_reg[i] - TMO_W'(1);
                end
            end
            addr_next = '0;
            nres_next = '0;
        end

        // hall floors already expired after the count-down; they decide the last flag
        if (cmd.tick_mask) begin
            for (int i = 0; i < FLOORS; i++) begin
                pend_next[i] = armed_reg[i] && (tleft_reg[i] == '0) &&
                               (req_reg[i][F_UP] || req_reg[i][F_DOWN]);
            end
        end

        if (cmd.scan_pick) begin
            btn_next = row[F_UP] ? BTN_UP : BTN_DOWN;
        end

        if (cmd.scan_disarm && addr_ok) begin
            armed_next[addr_reg] = 1'b0;
        end

        if (cmd.scan_next) begin
            addr_next = addr_reg + AW'(1);
        end

        if (addr_ok) begin
            case (cmd.act)
                ACT_FINISH: begin
                    req_next[addr_reg]   = '0;
                    armed_next[addr_reg] = 1'b0;
                end
                ACT_CLEAR: begin
                    req_next[addr_reg]   = row & CAB_MASK;
                    armed_next[addr_reg] = 1'b0;
                end
                ACT_DECIDE: begin
                    req_next[addr_reg] = row_dec;
                    if (hall) begin
                        armed_next[addr_reg] = 1'b1;
                        tleft_next[addr_reg] = tmo_ticks_reg;
                    end
                    if (tick_mode) begin
                        nres_next = nres_reg + RW'(1);
                        pend_next = pend_clr;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_comb begin
        send_valid_next  = 1'b0;
        send_kind_next   = 1'b0;
        send_floor_next  = '0;
        send_button_next = '0;
        send_cost_next   = '0;
        flags_next       = '0;
        last_next        = 1'b1;
        case (cmd.act)
            ACT_ROW: flags_next = row;
            ACT_FINISH: begin
                send_valid_next = 1'b1;
                send_kind_next  = 1'b1;
                send_floor_next = FLOOR_W'(addr_reg);
            end
            ACT_CLEAR: flags_next = row & CAB_MASK;
            ACT_DECIDE: begin
                flags_next = row_dec;
                last_next  = last_dec;
                if (hall && win) begin
                    send_valid_next  = 1'b1;
                    send_floor_next  = FLOOR_W'(addr_reg);
                    send_button_next = btn_reg;
                    send_cost_next   = cost_sat;
                end
            end
            default: ;
        endcase

        if (cmd.act != ACT_NONE) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FLOORS; i++) begin
                req_reg[i]   <= '0;
                tleft_reg[i] <= '0;
            end
            armed_reg     <= '0;
            pend_reg      <= '0;
            node_id_reg   <= '0;
            tmo_ticks_reg <= TMO_RST;
            addr_reg      <= '0;
            nres_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            req_reg       <= req_next;
            tleft_reg     <= tleft_next;
            armed_reg     <= armed_next;
            pend_reg      <= pend_next;
            node_id_reg   <= node_id_next;
            tmo_ticks_reg <= tmo_ticks_next;
            addr_reg      <= addr_next;
            nres_reg      <= nres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        btn_reg <= btn_next;
        if (cmd.load_in) begin
            in_cmd_reg   <= s_cmd;
            in_floor_reg <= s_floor;
            ext_reg      <= s_ext_cost;
            cur_reg      <= s_current_floor;
        end
        if (cmd.count) begin
            n_reg <= n_next;
        end
        if (cmd.cost) begin
            cost_reg <= cost_next;
        end
        if (cmd.act != ACT_NONE) begin
            send_valid_reg  <= send_valid_next;
            send_kind_reg   <= send_kind_next;
            send_floor_reg  <= send_floor_next;
            send_button_reg <= send_button_next;
            send_cost_reg   <= send_cost_next;
            flags_reg       <= flags_next;
            last_reg        <= last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_send_valid  = send_valid_reg;
    assign m_send_kind   = send_kind_reg;
    assign m_send_floor  = send_floor_reg;
    assign m_send_button = send_button_reg;
    assign m_send_cost   = send_cost_reg;
    assign m_floor_flags = flags_reg;
    assign m_last        = last_reg;

    always_comb begin
        status.op           = op;
        status.out_free     = !out_valid_reg || m_ready;
        status.tick_mode    = tick_mode;
        status.scan_expired = addr_ok && armed_reg[addr_reg] && (tleft_reg[addr_reg] == '0);
        status.scan_hall    = row[F_UP] || row[F_DOWN];
        status.scan_end     = (addr_reg == TOP_ADDR);
        status.rebid_full   = (nres_reg == RW'(MAX_RES - 1));
        status.none_sent    = (nres_reg == '0);
    end

endmodule

`default_nettype wire

[hdl/erc_ctrl.sv]
// Controller of the request cost bidder: one-hot sequencer over dispatch, cost and tick scan.
// Depends on erc_pkg; drives erc_datapath through ctl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module erc_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire erc_pkg::ctl_status_t  status,
    output erc_pkg::ctl_cmd_t          cmd
);
    import erc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_COUNT    = 8'b0000_0100,
        S_COST     = 8'b0000_1000,
        S_DECIDE   = 8'b0001_0000,
        S_TMASK    = 8'b0010_0000,
        S_SCAN     = 8'b0100_0000,
        S_TZERO    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.act    = ACT_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status.op)
                    OP_TICK: begin
                        cmd.tick_dec = 1'b1;
                        state_next   = S_TMASK;
                    end
                    OP_HANDLE: begin
                        cmd.set_flag = 1'b1;
                        state_next   = S_COUNT;
                    end
                    OP_ROW: begin
                        if (status.out_free) begin
                            cmd.act    = ACT_ROW;
                            state_next = S_IDLE;
                        end
                    end
                    OP_FINISH: begin
                        if (status.out_free) begin
                            cmd.act    = ACT_FINISH;
                            state_next = S_IDLE;
                        end
                    end
                    OP_CLEAR: begin
                        if (status.out_free) begin
                            cmd.act    = ACT_CLEAR;
                            state_next = S_IDLE;
                        end
                    end
                    default: begin
                        if (status.out_free) begin
                            cmd.act    = ACT_ZERO;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_COUNT: begin
                cmd.count  = 1'b1;
                state_next = S_COST;
            end
            S_COST: begin
                cmd.cost   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (status.out_free) begin
                    cmd.act = ACT_DECIDE;
                    if (!status.tick_mode || status.rebid_full || status.scan_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.scan_next = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_TMASK: begin
                cmd.tick_mask = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (status.scan_expired && status.scan_hall) begin
                    // flag is already set: straight to the cost stages
                    cmd.scan_pick = 1'b1;
                    state_next    = S_COUNT;
                end else begin
                    cmd.scan_disarm = status.scan_expired;
                    if (status.scan_end) begin
                        state_next = status.none_sent ? S_TZERO : S_IDLE;
                    end else begin
                        cmd.scan_next = 1'b1;
                    end
                end
            end
            S_TZERO: begin
                if (status.out_free) begin
                    cmd.act    = ACT_ZERO;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/elevator_request_cost_bidder.sv]
// Top level of the elevator request cost bidder: controller plus datapath.
// Depends on erc_pkg, erc_ctrl and erc_datapath.
//
//   channel | handshake                 | carries
//   --------+---------------------------+------------------------------------------------
//   cfg     | cfg_wr_en                 | cfg_index, cfg_wdata (node id, timeout ticks)
//   s_      | s_valid / s_ready         | cmd, floor, button, ext_cost, current_floor
//   m_      | m_valid / m_ready         | send_*, floor_flags, last
//
// One transaction at a time. Press or remote request: accept, dispatch, count, cost,
// decide. Finish, remote complete, press on a set flag, ignored input: accept, dispatch.
// Tick: accept, dispatch, mask, scan; count, cost, decide per re-bid floor; empty result
// if none is re-bid. Scan: one floor a cycle between re-bids, stops after the 4th re-bid.
// Result register decouples m_ready; a stalled result only holds the step that writes it.
// Reset (aresetn low, synchronous) clears the table, timeouts and config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module elevator_request_cost_bidder #(
    parameter int FLOORS = erc_pkg::FLOORS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [erc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [erc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [erc_pkg::CMD_W-1:0]       s_cmd,
    input  wire logic [erc_pkg::FLOOR_W-1:0]     s_floor,
    input  wire logic [erc_pkg::BTN_W-1:0]       s_button,
    input  wire logic [erc_pkg::EXT_W-1:0]       s_ext_cost,
    input  wire logic [erc_pkg::FLOOR_W-1:0]     s_current_floor,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_send_valid,
    output logic                                 m_send_kind,
    output logic [erc_pkg::FLOOR_W-1:0]          m_send_floor,
    output logic [erc_pkg::BTN_W-1:0]            m_send_button,
    output logic [erc_pkg::COST_W-1:0]           m_send_cost,
    output logic [erc_pkg::ROW_W-1:0]            m_floor_flags,
    output logic                                 m_last
);
    import erc_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    erc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    erc_datapath #(
        .FLOORS (FLOORS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_cmd           (s_cmd),
        .s_floor         (s_floor),
        .s_button        (s_button),
        .s_ext_cost      (s_ext_cost),
        .s_current_floor (s_current_floor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_valid    (m_send_valid),
        .m_send_kind     (m_send_kind),
        .m_send_floor    (m_send_floor),
        .m_send_button   (m_send_button),
        .m_send_cost     (m_send_cost),
        .m_floor_flags   (m_floor_flags),
        .m_last          (m_last),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire

[hdl/erc_checker.sv]
// Port-level checks for the elevator request cost bidder, bound to the top level.
// Depends on erc_pkg and elevator_request_cost_bidder.
`timescale 1ns / 1ps
`default_nettype none

module erc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic                            m_send_valid,
    input wire logic                            m_send_kind,
    input wire logic [erc_pkg::FLOOR_W-1:0]     m_send_floor,
    input wire logic [erc_pkg::BTN_W-1:0]       m_send_button,
    input wire logic [erc_pkg::COST_W-1:0]      m_send_cost,
    input wire logic [erc_pkg::ROW_W-1:0]       m_floor_flags,
    input wire logic                            m_last
);
    import erc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_send_valid) && $stable(m_send_kind) &&
            $stable(m_send_floor) && $stable(m_send_button) && $stable(m_send_cost) &&
            $stable(m_floor_flags) && $stable(m_last))
        else $error("result changed while stalled");

    // one transaction in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // completion notice carries a cleared row and no cost
    a_finish_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_kind |-> m_send_valid && m_last && m_floor_flags == '0 &&
            m_send_cost == '0 && m_send_button == BTN_UP)
        else $error("malformed completion notice");

    // a bid always leaves this node responsible for a hall call
    a_bid_owns: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_valid && !m_send_kind |->
            m_floor_flags[F_RESP] && (m_send_button == BTN_UP || m_send_button == BTN_DOWN))
        else $error("bid without responsibility");

    // no message: message fields stay zero
    a_quiet_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_valid |-> !m_send_kind && m_send_cost == '0 &&
            m_send_floor == '0 && m_send_button == '0)
        else $error("quiet result carries message data");

endmodule

bind elevator_request_cost_bidder erc_checker u_erc_checker (.*);

`default_nettype wire

[bench/erc_bid_checker.sv]
// Checker for the elevator request cost bidder: watches config writes and both channels,
// predicts every result from its own copy of the request table and compares in order.
// Depends on erc_pkg.
`timescale 1ns / 1ps

module erc_bid_checker #(
    parameter int FLOORS = erc_pkg::FLOORS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [erc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [erc_pkg::CMD_W-1:0]      s_cmd,
    input  logic [erc_pkg::FLOOR_W-1:0]    s_floor,
    input  logic [erc_pkg::BTN_W-1:0]      s_button,
    input  logic [erc_pkg::EXT_W-1:0]      s_ext_cost,
    input  logic [erc_pkg::FLOOR_W-1:0]    s_current_floor,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_send_valid,
    input  logic                           m_send_kind,
    input  logic [erc_pkg::FLOOR_W-1:0]    m_send_floor,
    input  logic [erc_pkg::BTN_W-1:0]      m_send_button,
    input  logic [erc_pkg::COST_W-1:0]     m_send_cost,
    input  logic [erc_pkg::ROW_W-1:0]      m_floor_flags,
    input  logic                           m_last,
    output int                             mismatches,
    output int                             outstanding
);
    import erc_pkg::*;

    localparam int unsigned COST_STEP = 255;

    typedef struct packed {
        logic               send_valid;
        logic               send_kind;
        logic [FLOOR_W-1:0] send_floor;
        logic [BTN_W-1:0]   send_button;
        logic [COST_W-1:0]  send_cost;
        logic [ROW_W-1:0]   floor_flags;
        logic               last;
    } bid_result_t;

    logic [ROW_W-1:0]  req_rows   [FLOORS];
    logic [TMO_W-1:0]  ticks_left [FLOORS];
    logic              armed      [FLOORS];
    logic [NODE_W-1:0] node_id_q;
    logic [TMO_W-1:0]  tmo_reload;

    bid_result_t pending_bids[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic string show(bid_result_t r);
        return $sformatf("send=%0d kind=%0d floor=%0d button=%0d cost=%0d flags=%h last=%0d",
                         r.send_valid, r.send_kind, r.send_floor, r.send_button,
                         r.send_cost, r.floor_flags, r.last);
    endfunction

    // distance plus one per floor with a cab call or an owned hall call
    function automatic int unsigned floor_cost(int unsigned fl, int unsigned cur);
        int unsigned n;
        int i;
        n = (fl > cur) ? fl - cur : cur - fl;
        for (i = 0; i < FLOORS; i++) begin
            if (req_rows[i][F_CAB])
                n++;
            else if (req_rows[i][F_RESP] && (req_rows[i][F_UP] || req_rows[i][F_DOWN]))
                n++;
        end
        return n * COST_STEP + node_id_q;
    endfunction

    // set the call, then bid / take / yield; infinite marks a local press or re-bid
    function automatic bid_result_t place_call(int unsigned fl, logic [BTN_W-1:0] btn,
                                               int unsigned ext, logic infinite,
                                               int unsigned cur);
        bid_result_t r;
        int unsigned cost;
        r = '0;
        req_rows[fl][btn] = 1'b1;
        cost = floor_cost(fl, cur);
        if (btn != BTN_CAB) begin
            ticks_left[fl] = tmo_reload;
            armed[fl] = 1'b1;
            if (infinite || cost < ext) begin
                req_rows[fl][F_RESP] = 1'b1;
                r.send_valid  = 1'b1;
                r.send_floor  = FLOOR_W'(fl);
                r.send_button = btn;
                r.send_cost   = (cost > COST_SAT) ? COST_SAT : COST_W'(cost);
                r.floor_flags = req_rows[fl];
                return r;
            end
            if (cost > ext)
                req_rows[fl][F_RESP] = 1'b0;
        end
        r.floor_flags = req_rows[fl];
        return r;
    endfunction

    task automatic apply_event(logic [CMD_W-1:0] cmd, int unsigned fl, logic [BTN_W-1:0] btn,
                               int unsigned ext, int unsigned cur);
        bid_result_t batch[$];
        bid_result_t r;
        int i;
        r = '0;
        if (cmd == CMD_TICK) begin
            for (i = 0; i < FLOORS; i++)
                if (armed[i] && ticks_left[i] != 0)
                    ticks_left[i]--;
            // armed counts at zero after the count-down expire
            for (i = 0; i < FLOORS && batch.size() < MAX_RES; i++) begin
                if (!armed[i] || ticks_left[i] != 0)
                    continue;
                if (req_rows[i][F_UP])
                    batch.push_back(place_call(i, BTN_UP, 0, 1'b1, cur));
                else if (req_rows[i][F_DOWN])
                    batch.push_back(place_call(i, BTN_DOWN, 0, 1'b1, cur));
                else
                    armed[i] = 1'b0;
            end
            if (batch.size() == 0)
                batch.push_back(r);
        end else begin
            if (cmd > CMD_TICK || fl >= FLOORS ||
                ((cmd == CMD_PRESS || cmd == CMD_REMOTE) && btn > BTN_CAB)) begin
                r = '0;
            end else if (cmd == CMD_PRESS) begin
                if (req_rows[fl][btn])
                    r.floor_flags = req_rows[fl];
                else
                    r = place_call(fl, btn, 0, 1'b1, cur);
            end else if (cmd == CMD_REMOTE) begin
                r = place_call(fl, btn, ext, 1'b0, cur);
            end else if (cmd == CMD_FINISH) begin
                req_rows[fl] = '0;
                armed[fl] = 1'b0;
                r.send_valid = 1'b1;
                r.send_kind  = 1'b1;
                r.send_floor = FLOOR_W'(fl);
            end else begin
                req_rows[fl][F_UP]   = 1'b0;
                req_rows[fl][F_DOWN] = 1'b0;
                req_rows[fl][F_RESP] = 1'b0;
                armed[fl] = 1'b0;
                r.floor_flags = req_rows[fl];
            end
            batch.push_back(r);
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pending_bids.push_back(batch[k]);
    endtask

    always @(posedge aclk) begin : watch
        bid_result_t got;
        bid_result_t want;
        int i;
        if (!aresetn) begin
            for (i = 0; i < FLOORS; i++) begin
                req_rows[i]   = '0;
                ticks_left[i] = '0;
                armed[i]      = 1'b0;
            end
            node_id_q  = '0;
            tmo_reload = TMO_RST;
            pending_bids.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_NODE_ID: node_id_q  = cfg_wdata;
                    CFG_TIMEOUT: tmo_reload = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                apply_event(s_cmd, 32'(s_floor), s_button, 32'(s_ext_cost),
                            32'(s_current_floor));
            if (m_valid && m_ready) begin
                got = '{m_send_valid, m_send_kind, m_send_floor, m_send_button,
                        m_send_cost, m_floor_flags, m_last};
                if (pending_bids.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %s", show(got));
                end else begin
                    want = pending_bids.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch\n  expected %s\n  actual   %s",
                                     show(want), show(got));
                    end
                end
            end
        end
        outstanding = pending_bids.size();
    end

endmodule

[bench/testbench.sv]
// Top of the bench: clock, reset, directed and random stimulus, result back-pressure.
// Depends on erc_pkg, elevator_request_cost_bidder and erc_bid_checker.
`timescale 1ns / 1ps

module testbench;
    import erc_pkg::*;

    localparam int          FLOORS       = FLOORS_DEF;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int          LONG_HOLD    = 400;
    localparam int          SETTLE       = 30;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd           = '0;
    logic [FLOOR_W-1:0]    s_floor         = '0;
    logic [BTN_W-1:0]      s_button        = '0;
    logic [EXT_W-1:0]      s_ext_cost      = '0;
    logic [FLOOR_W-1:0]    s_current_floor = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic                  m_send_valid;
    logic                  m_send_kind;
    logic [FLOOR_W-1:0]    m_send_floor;
    logic [BTN_W-1:0]      m_send_button;
    logic [COST_W-1:0]     m_send_cost;
    logic [ROW_W-1:0]      m_floor_flags;
    logic                  m_last;
    int                    mismatches;
    int                    outstanding;

    int items_offered = 0;
    int no_idle_left  = 0;
    int node_cfg      = 0;
    bit long_hold_done = 1'b0;

    elevator_request_cost_bidder #(.FLOORS(FLOORS)) dut (.*);

    erc_bid_checker #(.FLOORS(FLOORS)) bid_check (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // returns at the edge where the transaction is accepted
    task automatic offer_event(logic [CMD_W-1:0] cmd, logic [FLOOR_W-1:0] fl,
                               logic [BTN_W-1:0] btn, logic [EXT_W-1:0] ext,
                               logic [FLOOR_W-1:0] cur);
        int gap;
        gap = (no_idle_left > 0) ? 0 : pick_gap();
        if (no_idle_left > 0)
            no_idle_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_floor         <= fl;
        s_button        <= btn;
        s_ext_cost      <= ext;
        s_current_floor <= cur;
        items_offered++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_regs(int node, int tmo);
        node_cfg = node;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NODE_ID;
        cfg_wdata <= CFG_DATA_W'(node);
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= CFG_DATA_W'(tmo);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_event();
        logic [CMD_W-1:0] cmd;
        logic [BTN_W-1:0] btn;
        int unsigned pick;
        int ext;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            cmd = CMD_PRESS;
        else if (pick < 50)
            cmd = CMD_REMOTE;
        else if (pick < 60)
            cmd = CMD_FINISH;
        else if (pick < 70)
            cmd = CMD_REMOTE_DONE;
        else if (pick < 95)
            cmd = CMD_TICK;
        else
            cmd = CMD_W'($urandom_range(5, 7));
        btn = ($urandom_range(0, 15) == 0) ? BTN_BAD : BTN_W'($urandom_range(0, 2));
        // remote costs near our own so ties and near misses show up
        pick = $urandom_range(0, 3);
        if (pick < 2)
            ext = int'($urandom_range(0, 8)) * 255 + node_cfg + int'($urandom_range(0, 2)) - 1;
        else if (pick == 2)
            ext = $urandom_range(0, 65535);
        else
            ext = $urandom_range(0, 1) ? 65535 : 0;
        if (ext < 0)
            ext = 0;
        offer_event(cmd, FLOOR_W'($urandom_range(0, 3)), btn, EXT_W'(ext),
                    FLOOR_W'($urandom_range(0, 3)));
    endtask

    // result side back-pressure, with one long hold-off while the sender keeps going
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!long_hold_done && items_offered >= 60) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int i;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: node 0, 25 ticks
        offer_event(CMD_PRESS, 2'd0, BTN_UP, 16'd0, 2'd3);
        offer_event(CMD_PRESS, 2'd0, BTN_UP, 16'd0, 2'd3);       // already set
        offer_event(CMD_PRESS, 2'd3, BTN_DOWN, 16'hFFFF, 2'd0);
        offer_event(CMD_PRESS, 2'd1, BTN_CAB, 16'd0, 2'd2);
        offer_event(CMD_PRESS, 2'd1, BTN_CAB, 16'd0, 2'd2);
        offer_event(CMD_PRESS, 2'd2, BTN_BAD, 16'd0, 2'd1);
        offer_event(CMD_REMOTE, 2'd2, BTN_UP, 16'd0, 2'd2);      // we lose
        offer_event(CMD_REMOTE, 2'd2, BTN_DOWN, 16'hFFFF, 2'd2); // we win
        offer_event(CMD_REMOTE, 2'd2, BTN_UP, 16'd1020, 2'd2);   // tie with our cost
        offer_event(CMD_REMOTE, 2'd0, BTN_CAB, 16'd0, 2'd1);
        offer_event(CMD_REMOTE, 2'd1, BTN_BAD, 16'h5555, 2'd0);
        offer_event(CMD_REMOTE_DONE, 2'd3, BTN_UP, 16'd0, 2'd0);
        offer_event(CMD_FINISH, 2'd1, BTN_UP, 16'd0, 2'd1);
        offer_event(CMD_TICK, 2'd0, BTN_UP, 16'd0, 2'd0);
        offer_event(CMD_W'(5), 2'd2, BTN_DOWN, 16'hAAAA, 2'd2);
        offer_event(CMD_W'(7), 2'd3, BTN_BAD, 16'hFFFF, 2'd3);
        offer_event(CMD_REMOTE_DONE, 2'd1, BTN_CAB, 16'd0, 2'd1);
        wait_idle();

        // zero timeout: every floor armed from here on expires on the next tick
        write_regs(255, 0);
        offer_event(CMD_PRESS, 2'd0, BTN_UP, 16'd0, 2'd0);
        offer_event(CMD_PRESS, 2'd1, BTN_DOWN, 16'd0, 2'd3);
        offer_event(CMD_PRESS, 2'd2, BTN_UP, 16'd0, 2'd3);
        offer_event(CMD_PRESS, 2'd3, BTN_DOWN, 16'd0, 2'd3);
        offer_event(CMD_TICK, 2'd0, BTN_UP, 16'd0, 2'd1);
        offer_event(CMD_TICK, 2'd0, BTN_UP, 16'd0, 2'd2);
        offer_event(CMD_FINISH, 2'd0, BTN_UP, 16'd0, 2'd0);
        offer_event(CMD_TICK, 2'd0, BTN_UP, 16'd0, 2'd3);
        wait_idle();

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_regs(0, 1);
                1: write_regs(255, 3);
                2: write_regs($urandom_range(0, 255), 255);
                3: write_regs(37, 0);
                default: write_regs($urandom_range(0, 255), $urandom_range(1, 6));
            endcase
            for (i = 0; i < 25; i++) begin
                if (i % 15 == 0)
                    no_idle_left = 6;
                random_event();
            end
            wait_idle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
